// ===== sv/ulcd_pkg.sv =====
// ulcd_pkg: shared types, character codes, action codes and word tables
// for the serial line command decoder. No dependencies.
`timescale 1ns / 1ps

package ulcd_pkg;

  // action codes carried in the result word
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_BEEP  = 2'd3;

  localparam logic [15:0] BEEP_RESET = 16'd100;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_T     = 8'h74;

  // whole-line command words
  localparam logic [39:0] WORD_START = "start";
  localparam logic [31:0] WORD_STOP  = "stop";
  localparam logic [31:0] WORD_BEEP  = "beep";

  // number conversion phases
  localparam logic [1:0] NUM_LEAD  = 2'd0;
  localparam logic [1:0] NUM_DIGIT = 2'd1;
  localparam logic [1:0] NUM_DONE  = 2'd2;

  // accumulator wide enough for one step past the saturation limit
  localparam int ACC_W = 37;
  localparam logic [ACC_W-1:0] ACC_LIMIT = 37'd10000000000;
  localparam logic [ACC_W-1:0] ACC_POS_MAX = 37'd2147483647;
  localparam logic [ACC_W-1:0] ACC_NEG_MAX = 37'd2147483648;

  // controller to datapath commands
  typedef struct packed {
    logic store;  // keep a received byte in the line store
    logic init;   // terminator seen: latch content length, clear scan state
    logic step;   // scan one stored byte per cycle
    logic load;   // move the decoded line into the result register
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic term_byte;  // offered byte is CR or LF
    logic scan_end;   // all content bytes decoded
    logic out_busy;   // result register full and not taken this cycle
  } dp_stat_t;

  // byte idx of a command word, zero past its end
  function automatic logic [7:0] word_byte(input logic [1:0] act, input logic [2:0] idx);
    logic [7:0] b;
    b = CHAR_NUL;
    case (act)
      ACT_START: begin
        if (idx < 3'd5) b = WORD_START[8*(4-idx) +: 8];
      end
      ACT_STOP: begin
        if (idx < 3'd4) b = WORD_STOP[8*(3-idx) +: 8];
      end
      ACT_BEEP: begin
        if (idx < 3'd4) b = WORD_BEEP[8*(3-idx) +: 8];
      end
      default: b = CHAR_NUL;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] word_len(input logic [1:0] act);
    logic [2:0] n;
    case (act)
      ACT_START: n = 3'd5;
      ACT_STOP:  n = 3'd4;
      ACT_BEEP:  n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/ulcd_in_if.sv =====
// ulcd_in_if: received byte channel, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface ulcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink (input valid, input rx_data, output ready);
endinterface

// ===== sv/ulcd_out_if.sv =====
// ulcd_out_if: decoded line result channel, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface ulcd_out_if;
  logic               valid;
  logic               ready;
  logic               angle_valid;
  logic signed [31:0] steer_angle;
  logic [1:0]         action;
  logic [15:0]        beep_time;

  modport source (output valid, output angle_valid, output steer_angle, output action,
                  output beep_time, input ready);
  modport sink (input valid, input angle_valid, input steer_angle, input action,
                input beep_time, output ready);
endinterface

// ===== sv/ulcd_ctrl.sv =====
// ulcd_ctrl: sequencing state machine (collect, scan, finish).
// Depends on ulcd_pkg for the command and status structs.
`timescale 1ns / 1ps

module ulcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ulcd_pkg::dp_stat_t stat,
  output ulcd_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_FINISH  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_acc;

  // bytes are taken only while collecting
  assign in_ready = (state_r == S_COLLECT);
  assign in_acc   = in_valid && in_ready;

  // commands
  always_comb begin
    cmd.store = in_acc && !stat.term_byte;
    cmd.init  = in_acc && stat.term_byte;
    cmd.step  = (state_r == S_SCAN);
    cmd.load  = (state_r == S_FINISH) && !stat.out_busy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_COLLECT: begin
        if (in_acc && stat.term_byte) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_end) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_nxt = S_COLLECT;
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/ulcd_datapath.sv =====
// ulcd_datapath: line store, byte-serial line decoder, config register
// and result register. Depends on ulcd_pkg and ulcd_out_if.
`timescale 1ns / 1ps

module ulcd_datapath #(
  parameter int LINE_BYTES = 16,
  localparam int AW = $clog2(LINE_BYTES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ulcd_pkg::ctl_cmd_t cmd,
  output ulcd_pkg::dp_stat_t stat,
  input  logic [7:0]         rx_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  ulcd_out_if.source         out_ch
);

  localparam logic [AW-1:0] CNT_FULL = AW'(LINE_BYTES - 1);
  localparam logic [AW-1:0] CNT_KEEP = AW'(LINE_BYTES - 2);

  // line store
  logic [7:0] mem [LINE_BYTES];
  logic [7:0] rd_data_r;

  // fill and scan control
  logic [AW-1:0] cnt_r, m_r, rd_idx_r;
  logic          pend_r, stop_r, rd_go;

  // whole-line word match
  logic [2:0] wpos_r, wpos_nxt;
  logic       mst_r, mst_nxt, msp_r, msp_nxt, mbp_r, mbp_nxt;

  // token and pair state
  logic             tok_any_r, tok_any_nxt;
  logic [1:0]       tpos_r, tpos_nxt;
  logic             tok_ta_r, tok_ta_nxt;
  logic             have_cmd_r, have_cmd_nxt;
  logic             cmd_ta_r, cmd_ta_nxt;
  logic             ang_valid_r, ang_valid_nxt;
  logic [31:0]      angle_r, angle_nxt;

  // number conversion
  logic [1:0]                 ph_r, ph_nxt;
  logic                       neg_r, neg_nxt;
  logic [ulcd_pkg::ACC_W-1:0] acc_r, acc_nxt, acc_step;
  logic [31:0]                clamp_val;

  // config and result registers
  logic [15:0] beep_dur_r;
  logic        out_valid_r;
  logic        o_angle_valid_r;
  logic [31:0] o_angle_r;
  logic [1:0]  o_action_r;
  logic [15:0] o_beep_r;

  logic [7:0] c;
  logic       proc, is_sep, is_digit, is_ws, tok_is_ta, pair_hit;
  logic       fin_valid;
  logic [31:0] fin_angle;
  logic [1:0]  fin_action;

  assign c        = rd_data_r;
  assign proc     = pend_r && !stop_r && (c != ulcd_pkg::CHAR_NUL);
  assign is_sep   = (c == ulcd_pkg::CHAR_COLON) || (c == ulcd_pkg::CHAR_COMMA);
  assign is_digit = (c >= ulcd_pkg::CHAR_ZERO) && (c <= ulcd_pkg::CHAR_NINE);
  assign is_ws    = (c == ulcd_pkg::CHAR_SPACE) ||
                    ((c >= ulcd_pkg::CHAR_TAB) && (c <= ulcd_pkg::CHAR_CR));
  assign tok_is_ta = tok_ta_r && (tpos_r == 2'd2);
  assign pair_hit  = tok_any_r && have_cmd_r && cmd_ta_r;
  assign acc_step  = (acc_r << 3) + (acc_r << 1) + {{(ulcd_pkg::ACC_W-4){1'b0}}, c[3:0]};

  // saturate the current token's value to 32 bits
  always_comb begin
    if (neg_r) begin
      clamp_val = (acc_r > ulcd_pkg::ACC_NEG_MAX) ? 32'h8000_0000 : (32'd0 - acc_r[31:0]);
    end else begin
      clamp_val = (acc_r > ulcd_pkg::ACC_POS_MAX) ? 32'h7FFF_FFFF : acc_r[31:0];
    end
  end

  // status to the controller
  always_comb begin
    stat.term_byte = (rx_data == ulcd_pkg::CHAR_CR) || (rx_data == ulcd_pkg::CHAR_LF);
    stat.scan_end  = stop_r || ((rd_idx_r == m_r) && !pend_r);
    stat.out_busy  = out_valid_r && !out_ch.ready;
  end

  // line store write and registered scan read
  assign rd_go = cmd.step && !stop_r && (rd_idx_r != m_r);

  always_ff @(posedge clk) begin
    if (cmd.store && (cnt_r < CNT_FULL)) mem[cnt_r] <= rx_data;
    if (rd_go) rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      m_r      <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      stop_r   <= 1'b0;
    end else begin
      if (cmd.store && (cnt_r < CNT_FULL)) cnt_r <= cnt_r + 1'b1;
      if (cmd.init) begin
        // a full store loses its last byte to the terminator clear
        m_r      <= (cnt_r == CNT_FULL) ? CNT_KEEP : cnt_r;
        cnt_r    <= '0;
        rd_idx_r <= '0;
        pend_r   <= 1'b0;
        stop_r   <= 1'b0;
      end else begin
        pend_r <= rd_go;
        if (rd_go) rd_idx_r <= rd_idx_r + 1'b1;
        if (pend_r && !stop_r && (c == ulcd_pkg::CHAR_NUL)) stop_r <= 1'b1;
      end
    end
  end

  // per-byte decode step
  always_comb begin
    wpos_nxt      = wpos_r;
    mst_nxt       = mst_r;
    msp_nxt       = msp_r;
    mbp_nxt       = mbp_r;
    tok_any_nxt   = tok_any_r;
    tpos_nxt      = tpos_r;
    tok_ta_nxt    = tok_ta_r;
    have_cmd_nxt  = have_cmd_r;
    cmd_ta_nxt    = cmd_ta_r;
    ang_valid_nxt = ang_valid_r;
    angle_nxt     = angle_r;
    ph_nxt        = ph_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    if (cmd.init) begin
      wpos_nxt      = 3'd0;
      mst_nxt       = 1'b1;
      msp_nxt       = 1'b1;
      mbp_nxt       = 1'b1;
      tok_any_nxt   = 1'b0;
      tpos_nxt      = 2'd0;
      tok_ta_nxt    = 1'b1;
      have_cmd_nxt  = 1'b0;
      cmd_ta_nxt    = 1'b0;
      ang_valid_nxt = 1'b0;
      angle_nxt     = 32'd0;
      ph_nxt        = ulcd_pkg::NUM_LEAD;
      neg_nxt       = 1'b0;
      acc_nxt       = '0;
    end else if (proc) begin
      // whole-line compare against the command words
      mst_nxt = mst_r && (c == ulcd_pkg::word_byte(ulcd_pkg::ACT_START, wpos_r));
      msp_nxt = msp_r && (c == ulcd_pkg::word_byte(ulcd_pkg::ACT_STOP, wpos_r));
      mbp_nxt = mbp_r && (c == ulcd_pkg::word_byte(ulcd_pkg::ACT_BEEP, wpos_r));
      if (wpos_r != 3'd7) wpos_nxt = wpos_r + 3'd1;

      if (is_sep) begin
        // token ends; empty tokens leave the pair state alone
        if (tok_any_r) begin
          if (c == ulcd_pkg::CHAR_COLON) begin
            have_cmd_nxt = 1'b1;
            cmd_ta_nxt   = tok_is_ta;
          end else begin
            if (have_cmd_r && cmd_ta_r) begin
              angle_nxt     = clamp_val;
              ang_valid_nxt = 1'b1;
            end
            have_cmd_nxt = 1'b0;
          end
        end
        tok_any_nxt = 1'b0;
        tpos_nxt    = 2'd0;
        tok_ta_nxt  = 1'b1;
        ph_nxt      = ulcd_pkg::NUM_LEAD;
        neg_nxt     = 1'b0;
        acc_nxt     = '0;
      end else begin
        tok_any_nxt = 1'b1;
        tok_ta_nxt  = tok_ta_r &&
                      (((tpos_r == 2'd0) && (c == ulcd_pkg::CHAR_T)) ||
                       ((tpos_r == 2'd1) && (c == ulcd_pkg::CHAR_A)));
        if (tpos_r != 2'd3) tpos_nxt = tpos_r + 2'd1;
        // decimal conversion with leading blanks and optional sign
        case (ph_r)
          ulcd_pkg::NUM_LEAD: begin
            if (is_ws) begin
              ph_nxt = ulcd_pkg::NUM_LEAD;
            end else if ((c == ulcd_pkg::CHAR_PLUS) || (c == ulcd_pkg::CHAR_MINUS)) begin
              neg_nxt = (c == ulcd_pkg::CHAR_MINUS);
              ph_nxt  = ulcd_pkg::NUM_DIGIT;
            end else if (is_digit) begin
              acc_nxt = acc_step;
              ph_nxt  = ulcd_pkg::NUM_DIGIT;
            end else begin
              ph_nxt = ulcd_pkg::NUM_DONE;
            end
          end
          ulcd_pkg::NUM_DIGIT: begin
            if (is_digit) begin
              if (acc_r < ulcd_pkg::ACC_LIMIT) acc_nxt = acc_step;
            end else begin
              ph_nxt = ulcd_pkg::NUM_DONE;
            end
          end
          default: ph_nxt = ulcd_pkg::NUM_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wpos_r      <= wpos_nxt;
    mst_r       <= mst_nxt;
    msp_r       <= msp_nxt;
    mbp_r       <= mbp_nxt;
    tok_any_r   <= tok_any_nxt;
    tpos_r      <= tpos_nxt;
    tok_ta_r    <= tok_ta_nxt;
    have_cmd_r  <= have_cmd_nxt;
    cmd_ta_r    <= cmd_ta_nxt;
    ang_valid_r <= ang_valid_nxt;
    angle_r     <= angle_nxt;
    ph_r        <= ph_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
  end

  // line end closes the open token and settles the action
  always_comb begin
    fin_valid = ang_valid_r || pair_hit;
    fin_angle = pair_hit ? clamp_val : angle_r;
    if (mst_r && (wpos_r == ulcd_pkg::word_len(ulcd_pkg::ACT_START))) begin
      fin_action = ulcd_pkg::ACT_START;
    end else if (msp_r && (wpos_r == ulcd_pkg::word_len(ulcd_pkg::ACT_STOP))) begin
      fin_action = ulcd_pkg::ACT_STOP;
    end else if (mbp_r && (wpos_r == ulcd_pkg::word_len(ulcd_pkg::ACT_BEEP))) begin
      fin_action = ulcd_pkg::ACT_BEEP;
    end else begin
      fin_action = ulcd_pkg::ACT_NONE;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_dur_r <= ulcd_pkg::BEEP_RESET;
    end else if (cfg_we) begin
      beep_dur_r <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      o_angle_valid_r <= fin_valid;
      o_angle_r       <= fin_angle;
      o_action_r      <= fin_action;
      o_beep_r        <= (fin_action == ulcd_pkg::ACT_BEEP) ? beep_dur_r : 16'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.angle_valid = o_angle_valid_r;
  assign out_ch.steer_angle = o_angle_r;
  assign out_ch.action      = o_action_r;
  assign out_ch.beep_time   = o_beep_r;

endmodule

// ===== sv/uart_line_command_decoder_unit.sv =====
// Serial line command decoder, top level: controller plus datapath.
// Bytes other than CR/LF are stored as they are taken; a terminator starts a scan of the m stored
// content bytes (m <= LINE_BYTES-2), one per cycle through the single store read port.
// A zero byte in the content cuts the scan short. The result is loaded once the scan ends,
// later while the previous result waits; input is taken again from the cycle in which it
// becomes valid. Reset empties the line and result, beep duration = 100.
`timescale 1ns / 1ps

module uart_line_command_decoder_unit #(
  parameter int LINE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ulcd_in_if.sink     in_ch,
  ulcd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  ulcd_pkg::ctl_cmd_t cmd;
  ulcd_pkg::dp_stat_t stat;

  // sequencing
  ulcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and decode
  ulcd_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .rx_data   (in_ch.rx_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/ulcd_checker.sv =====
// ulcd_checker: port-level checks on the decoder, bound to the top level.
// Depends on ulcd_pkg and uart_line_command_decoder_unit.
`timescale 1ns / 1ps

module ulcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_angle_valid,
  input logic [31:0] out_steer_angle,
  input logic [1:0]  out_action,
  input logic [15:0] out_beep_time
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_steer_angle) &&
    $stable(out_action) && $stable(out_beep_time) && $stable(out_angle_valid))
    else $error("result word changed while stalled");

  // a line terminator starts a decode, so input closes next cycle
  a_term_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_rx_data == ulcd_pkg::CHAR_CR || in_rx_data == ulcd_pkg::CHAR_LF) |=> !in_ready)
    else $error("input still open after line terminator");

  // beep time only with a beep action
  a_beep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ulcd_pkg::ACT_BEEP) |-> out_beep_time == 16'd0)
    else $error("beep time without beep action");

  // no angle reported without a ta pair
  a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_angle_valid |-> out_steer_angle == 32'd0)
    else $error("steer angle nonzero without angle_valid");

endmodule

bind uart_line_command_decoder_unit ulcd_checker u_ulcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_rx_data      (in_ch.rx_data),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_angle_valid (out_ch.angle_valid),
  .out_steer_angle (out_ch.steer_angle),
  .out_action      (out_ch.action),
  .out_beep_time   (out_ch.beep_time)
);

// ===== sim/uart_line_command_decoder_unit_tb.sv =====
// Self-checking testbench for uart_line_command_decoder_unit: byte lines in,
// decoded results out, checked against an in-bench line decoder.
// Depends on ulcd_pkg, ulcd_in_if, ulcd_out_if.
`timescale 1ns / 1ps

module uart_line_command_decoder_unit_tb;

  localparam int LINE_BYTES = 16;
  localparam int QUIET_CYCLES = 24;
  localparam longint DIGIT_CAP = 64'd10000000000;
  localparam longint INT32_MAX = 64'sd2147483647;
  localparam longint INT32_MIN = -64'sd2147483648;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  typedef struct packed {
    logic               angle_valid;
    logic signed [31:0] steer_angle;
    logic [1:0]         action;
    logic [15:0]        beep_time;
  } line_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ulcd_in_if  in_ch ();
  ulcd_out_if out_ch ();

  uart_line_command_decoder_unit #(
    .LINE_BYTES(LINE_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the line store and the beep register
  logic [7:0]   line_buf [LINE_BYTES];
  int unsigned  line_len;
  logic [15:0]  beep_dur;

  logic [7:0]   tx_bytes [$];
  line_result_t pending_results [$];
  line_result_t head_result;

  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int bytes_queued;
  int bytes_sent = 0;
  int lines_checked = 0;
  int angles_seen = 0;
  int actions_seen [4] = '{default: 0};

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // true when the stored segment equals the word exactly
  function automatic bit seg_is(input int unsigned s, input int unsigned len, input string w);
    int unsigned i;
    if (len != w.len()) return 1'b0;
    for (i = 0; i < len; i++) begin
      if (line_buf[s+i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // decimal conversion: blanks, optional sign, digits, saturated to 32 bits
  function automatic logic signed [31:0] parse_int(input int unsigned s, input int unsigned len);
    int unsigned i;
    bit          neg;
    longint      acc;
    i = 0;
    neg = 1'b0;
    acc = 0;
    while (i < len && (line_buf[s+i] == ulcd_pkg::CHAR_SPACE ||
                       (line_buf[s+i] >= ulcd_pkg::CHAR_TAB &&
                        line_buf[s+i] <= ulcd_pkg::CHAR_CR))) i++;
    if (i < len && (line_buf[s+i] == ulcd_pkg::CHAR_PLUS ||
                    line_buf[s+i] == ulcd_pkg::CHAR_MINUS)) begin
      neg = (line_buf[s+i] == ulcd_pkg::CHAR_MINUS);
      i++;
    end
    while (i < len && line_buf[s+i] >= ulcd_pkg::CHAR_ZERO &&
           line_buf[s+i] <= ulcd_pkg::CHAR_NINE) begin
      if (acc < DIGIT_CAP) acc = acc * 10 + longint'(line_buf[s+i] - ulcd_pkg::CHAR_ZERO);
      i++;
    end
    if (neg) acc = -acc;
    if (acc > INT32_MAX) acc = INT32_MAX;
    if (acc < INT32_MIN) acc = INT32_MIN;
    return acc[31:0];
  endfunction

  // decode the stored line at a terminator
  function automatic line_result_t decode_line();
    line_result_t r;
    int unsigned  n, p, seg_s, seg_l, cmd_s, cmd_l;
    bit           have_cmd;
    r = '0;
    have_cmd = 1'b0;
    cmd_s = 0;
    cmd_l = 0;
    if (line_len > 0) line_buf[line_len-1] = ulcd_pkg::CHAR_NUL;
    n = 0;
    while (n < line_len && line_buf[n] != ulcd_pkg::CHAR_NUL) n++;
    // split into cmd:param pairs
    p = 0;
    while (p < n) begin
      seg_s = p;
      while (p < n && line_buf[p] != ulcd_pkg::CHAR_COLON &&
             line_buf[p] != ulcd_pkg::CHAR_COMMA) p++;
      seg_l = p - seg_s;
      if (seg_l == 0) begin
        if (p < n) p++;
      end else if (p < n && line_buf[p] == ulcd_pkg::CHAR_COLON) begin
        have_cmd = 1'b1;
        cmd_s = seg_s;
        cmd_l = seg_l;
        p++;
      end else begin
        if (have_cmd && seg_is(cmd_s, cmd_l, "ta")) begin
          r.steer_angle = parse_int(seg_s, seg_l);
          r.angle_valid = 1'b1;
        end
        have_cmd = 1'b0;
        if (p < n) p++;
      end
    end
    // whole-line commands
    if (seg_is(0, n, "start")) r.action = ulcd_pkg::ACT_START;
    else if (seg_is(0, n, "stop")) r.action = ulcd_pkg::ACT_STOP;
    else if (seg_is(0, n, "beep")) r.action = ulcd_pkg::ACT_BEEP;
    else r.action = ulcd_pkg::ACT_NONE;
    r.beep_time = (r.action == ulcd_pkg::ACT_BEEP) ? beep_dur : 16'd0;
    return r;
  endfunction

  // one accepted byte into the shadow line
  task automatic take_byte(input logic [7:0] b);
    if (line_len < LINE_BYTES - 1) begin
      line_buf[line_len] = b;
      line_len++;
    end
    if (b == ulcd_pkg::CHAR_LF || b == ulcd_pkg::CHAR_CR) begin
      pending_results.push_back(decode_line());
      line_len = 0;
    end
  endtask

  // driver: offers queued bytes, predicts on each accepted byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_data <= ulcd_pkg::CHAR_NUL;
      line_len = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        take_byte(in_ch.rx_data);
        bytes_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.rx_data <= tx_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compares each result word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: angle_valid %0d steer_angle %0d",
                   $time, out_ch.angle_valid, out_ch.steer_angle);
          $display("%0t:   action %0d beep_time %0d", $time, out_ch.action, out_ch.beep_time);
          errors++;
        end else begin
          head_result = pending_results.pop_front();
          if (out_ch.angle_valid !== head_result.angle_valid) begin
            $display("%0t: angle_valid expected %0d actual %0d",
                     $time, head_result.angle_valid, out_ch.angle_valid);
            errors++;
          end
          if (out_ch.steer_angle !== head_result.steer_angle) begin
            $display("%0t: steer_angle expected %0d actual %0d",
                     $time, head_result.steer_angle, out_ch.steer_angle);
            errors++;
          end
          if (out_ch.action !== head_result.action) begin
            $display("%0t: action expected %0d actual %0d",
                     $time, head_result.action, out_ch.action);
            errors++;
          end
          if (out_ch.beep_time !== head_result.beep_time) begin
            $display("%0t: beep_time expected %0d actual %0d",
                     $time, head_result.beep_time, out_ch.beep_time);
            errors++;
          end
          lines_checked++;
          if (head_result.angle_valid) angles_seen++;
          actions_seen[head_result.action]++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // atoi-style parameter: optional blank, optional sign, digits, rare trailing junk
  task automatic add_param(input int max_digits);
    int nd;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: push_byte(ulcd_pkg::CHAR_SPACE);
        1: push_byte(ulcd_pkg::CHAR_TAB);
        2: push_byte(CHAR_VT);
        default: push_byte(CHAR_FF);
      endcase
    end
    case ($urandom_range(3))
      0: push_byte(ulcd_pkg::CHAR_PLUS);
      1: push_byte(ulcd_pkg::CHAR_MINUS);
      default: ;
    endcase
    nd = ($urandom_range(7) == 0) ? $urandom_range(max_digits) : $urandom_range(1, 4);
    repeat (nd) push_byte(ulcd_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(7) == 0) push_text("x");
  endtask

  // one random line: mostly well-formed commands, some noise and broken lines
  task automatic add_line();
    int    kind, n, j;
    string junk;
    junk = ":,ta+-0123456789 xs";
    kind = $urandom_range(19);
    case (kind)
      0: push_text("start");
      1: push_text("stop");
      2: push_text("beep");
      3: begin
        case ($urandom_range(3))
          0: push_text("sto");
          1: push_text("starts");
          2: push_text("beep ");
          default: push_text("ta");
        endcase
      end
      13, 14, 15: begin
        n = $urandom_range(14);
        repeat (n) push_byte(junk[$urandom_range(junk.len() - 1)]);
      end
      16, 17: begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(255)));
      end
      18, 19: begin
        // overlong lines: truncation and saturation
        if ($urandom_range(1) == 0) begin
          push_text("ta:");
          add_param(19);
          repeat ($urandom_range(8)) push_byte(ulcd_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end else begin
          repeat ($urandom_range(3, 5)) push_text("ta:1,");
          push_text("ta:");
          add_param(6);
        end
      end
      default: begin
        n = $urandom_range(1, 3);
        for (j = 0; j < n; j++) begin
          if (j > 0) push_byte(ulcd_pkg::CHAR_COMMA);
          if ($urandom_range(9) != 0) begin
            case ($urandom_range(7))
              4: push_text("tb");
              5: push_text("t");
              6: push_text("a");
              7: ;
              default: push_text("ta");
            endcase
            push_byte(ulcd_pkg::CHAR_COLON);
          end
          if ($urandom_range(9) != 0) add_param(12);
        end
      end
    endcase
    push_byte($urandom_range(1) ? ulcd_pkg::CHAR_CR : ulcd_pkg::CHAR_LF);
    if ($urandom_range(9) == 0) push_byte($urandom_range(1) ? ulcd_pkg::CHAR_CR : ulcd_pkg::CHAR_LF);
  endtask

  task automatic add_lines(input int count);
    int base;
    base = bytes_queued;
    while (bytes_queued - base < count) add_line();
  endtask

  // wait until every byte is taken and every result checked, then let the block settle
  task automatic drain();
    do @(posedge clk);
    while (tx_bytes.size() > 0 || in_ch.valid || pending_results.size() > 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_beep(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    beep_dur = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sequence: reset, directed lines, three random phases at different beep settings
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    beep_dur = ulcd_pkg::BEEP_RESET;
    bytes_queued = 0;
    send_idle_pct = 23;
    recv_idle_pct = 77;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: each command with reset beep value, full store with saturation,
    // all-ones byte and a zero byte ending the content
    push_text("start");
    push_byte(ulcd_pkg::CHAR_CR);
    push_text("stop");
    push_byte(ulcd_pkg::CHAR_LF);
    push_text("beep");
    push_byte(ulcd_pkg::CHAR_LF);
    push_text("ta:-9999999999x");
    push_byte(ulcd_pkg::CHAR_LF);
    push_byte(8'hFF);
    push_byte(ulcd_pkg::CHAR_NUL);
    push_byte(ulcd_pkg::CHAR_CR);
    drain();

    write_beep(16'd0);
    push_text("beep");
    push_byte(ulcd_pkg::CHAR_CR);
    add_lines(500);
    drain();

    write_beep(16'hFFFF);
    send_idle_pct = 77;
    recv_idle_pct = 23;
    push_text("beep");
    push_byte(ulcd_pkg::CHAR_LF);
    add_lines(500);
    drain();

    write_beep(16'($urandom_range(65535)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_lines(400);
    drain();

    $display("sent %0d bytes over four beep settings, checked %0d lines (%0d with angle)",
             bytes_sent, lines_checked, angles_seen);
    $display("actions: none %0d, start %0d, stop %0d, beep %0d",
             actions_seen[ulcd_pkg::ACT_NONE], actions_seen[ulcd_pkg::ACT_START],
             actions_seen[ulcd_pkg::ACT_STOP], actions_seen[ulcd_pkg::ACT_BEEP]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
